// ===== rtl/bhe_pkg.sv =====
// Shared types and constants of the bitmap hit enumerator.
package bhe_pkg;

    localparam int WORD_BITS     = 32;
    localparam int POS_W         = 5;
    localparam int INDEX_W       = 21;
    localparam int HITS_W        = 22;
    localparam int WNUM_W        = INDEX_W - POS_W;
    localparam int MAP_WORDS_DEF = 65536;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = QPTR_W + 1;

    typedef struct packed {
        logic                  start;
        logic [WORD_BITS-1:0]  word;
        logic [WNUM_W-1:0]     wnum;
    } bhe_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } bhe_qstat_t;

endpackage

// ===== rtl/bhe_front.sv =====
// Front end: accepts bitmap words, keeps the word counter and queues work.
module bhe_front #(
    parameter int MAP_WORDS = bhe_pkg::MAP_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bhe_pkg::WORD_BITS-1:0] map_word,
    input  logic                          map_start,
    input  bhe_pkg::bhe_qstat_t           qstat,
    output logic                          push,
    output bhe_pkg::bhe_entry_t           push_entry
);

    localparam int WC_W = $clog2(MAP_WORDS + 1);

    logic [WC_W-1:0]                      wc_reg;
    logic [WC_W-1:0]                      wc_next;
    logic [WC_W-1:0]                      wc_eff;
    logic [WC_W+bhe_pkg::WNUM_W-1:0]      wc_ext;
    logic                                 accept;
    logic                                 in_map;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign wc_eff   = map_start ? '0 : wc_reg;
    assign in_map   = wc_eff < WC_W'(MAP_WORDS);
    assign wc_ext   = {{bhe_pkg::WNUM_W{1'b0}}, wc_eff};

    always_comb
    begin
        wc_next = wc_reg;
        if (accept)
        begin
            wc_next = in_map ? wc_eff + WC_W'(1) : WC_W'(MAP_WORDS);
        end
    end

    assign push             = accept && in_map && (map_start || (map_word != '0));
    assign push_entry.start = map_start;
    assign push_entry.word  = map_word;
    assign push_entry.wnum  = wc_ext[bhe_pkg::WNUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg <= '0;
        end
        else
        begin
            wc_reg <= wc_next;
        end
    end

endmodule

// ===== rtl/bhe_fifo.sv =====
// Short queue of classified words between the front and back ends.
module bhe_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bhe_pkg::bhe_entry_t push_entry,
    input  logic                pop,
    output bhe_pkg::bhe_entry_t head,
    output bhe_pkg::bhe_qstat_t qstat
);

    bhe_pkg::bhe_entry_t                mem_reg [bhe_pkg::QUEUE_DEPTH];
    logic [bhe_pkg::QPTR_W-1:0]         wptr_reg;
    logic [bhe_pkg::QPTR_W-1:0]         wptr_next;
    logic [bhe_pkg::QPTR_W-1:0]         rptr_reg;
    logic [bhe_pkg::QPTR_W-1:0]         rptr_next;
    logic [bhe_pkg::QCNT_W-1:0]         cnt_reg;
    logic [bhe_pkg::QCNT_W-1:0]         cnt_next;

    assign head        = mem_reg[rptr_reg];
    assign qstat.valid = cnt_reg != '0;
    assign qstat.full  = cnt_reg == bhe_pkg::QCNT_W'(bhe_pkg::QUEUE_DEPTH);

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == bhe_pkg::QPTR_W'(bhe_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : wptr_reg + bhe_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == bhe_pkg::QPTR_W'(bhe_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : rptr_reg + bhe_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + bhe_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - bhe_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qstat.valid)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !qstat.full)
        else $error("queue pushed while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= bhe_pkg::QCNT_W'(bhe_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/bhe_back.sv =====
// Back end: scans queued words one set bit per cycle while the output is not stalled and emits hit words.
module bhe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bhe_pkg::bhe_entry_t           head,
    input  bhe_pkg::bhe_qstat_t           qstat,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bhe_pkg::INDEX_W-1:0]   hit_index,
    output logic [bhe_pkg::HITS_W-1:0]    hit_number,
    output logic                          last_in_word
);

    logic                              busy_reg;
    logic                              busy_next;
    logic [bhe_pkg::WORD_BITS-1:0]     rem_reg;
    logic [bhe_pkg::WORD_BITS-1:0]     rem_next;
    logic [bhe_pkg::WORD_BITS-1:0]     rem_clr;
    logic [bhe_pkg::WNUM_W-1:0]        wnum_reg;
    logic [bhe_pkg::HITS_W-1:0]        hit_reg;
    logic [bhe_pkg::HITS_W-1:0]        hit_next;
    logic [bhe_pkg::HITS_W-1:0]        hit_inc;
    logic                              ov_reg;
    logic                              ov_next;
    logic [bhe_pkg::INDEX_W-1:0]       idx_reg;
    logic [bhe_pkg::HITS_W-1:0]        num_reg;
    logic                              last_reg;
    logic [bhe_pkg::POS_W-1:0]         pos;
    logic                              emit;
    logic                              room;

    assign room = !ov_reg || !out_stall;
    assign pop  = !busy_reg && qstat.valid;
    assign emit = busy_reg && room;

    always_comb
    begin
        pos = '0;
        for (int i = bhe_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (rem_reg[bhe_pkg::WORD_BITS - 1 - i])
            begin
                pos = bhe_pkg::POS_W'(i);
            end
        end
    end

    always_comb
    begin
        rem_clr = rem_reg;
        rem_clr[bhe_pkg::POS_W'(bhe_pkg::WORD_BITS - 1) - pos] = 1'b0;
    end

    assign hit_inc = (hit_reg == '1) ? hit_reg : hit_reg + bhe_pkg::HITS_W'(1);

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        hit_next  = hit_reg;
        ov_next   = ov_reg && out_stall;
        if (pop)
        begin
            rem_next  = head.word;
            busy_next = head.word != '0;
            if (head.start)
            begin
                hit_next = '0;
            end
        end
        else if (emit)
        begin
            rem_next  = rem_clr;
            busy_next = rem_clr != '0;
            hit_next  = hit_inc;
            ov_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            wnum_reg <= head.wnum;
        end
        if (emit)
        begin
            idx_reg  <= {wnum_reg, pos};
            num_reg  <= hit_inc;
            last_reg <= rem_clr == '0;
        end
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            hit_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            hit_reg  <= hit_next;
            ov_reg   <= ov_next;
        end
    end

    assign out_valid    = ov_reg;
    assign hit_index    = idx_reg;
    assign hit_number   = num_reg;
    assign last_in_word = last_reg;

    a_busy_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg != '0))
        else $error("scanner busy with an empty word");

    a_last_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (rem_clr == '0)) |=> !busy_reg)
        else $error("scanner still busy after the last hit of a word");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (num_reg != '0))
        else $error("hit word with a zero hit count");

endmodule

// ===== rtl/bitmap_hit_enumerator.sv =====
// Top level of the bitmap hit enumerator.
// Each accepted 32-bit bitmap word is classified by the front end in the cycle it is
// accepted and queued; the back end then emits one hit word per cycle for each set bit
// while the output is not stalled, scanning from bit 31 (position 0) down to bit 0. The
// back end first takes a word from the queue and then emits one hit per set bit; a word
// with no set bits or past the map is not queued unless it carries a start flag, and the
// back end takes such a start word from the queue without emitting a hit.
module bitmap_hit_enumerator #(
    parameter int MAP_WORDS = bhe_pkg::MAP_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bhe_pkg::WORD_BITS-1:0] map_word,
    input  logic                          map_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bhe_pkg::INDEX_W-1:0]   hit_index,
    output logic [bhe_pkg::HITS_W-1:0]    hit_number,
    output logic                          last_in_word
);

    bhe_pkg::bhe_qstat_t qstat;
    bhe_pkg::bhe_entry_t push_entry;
    bhe_pkg::bhe_entry_t head;
    logic                push;
    logic                pop;

    bhe_front #(
        .MAP_WORDS (MAP_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .map_word   (map_word),
        .map_start  (map_start),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    bhe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    bhe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit_index    (hit_index),
        .hit_number   (hit_number),
        .last_in_word (last_in_word)
    );

endmodule

// ===== tb/bitmap_hit_enumerator_tb.sv =====
// Self-checking testbench for the bitmap hit enumerator with a scoreboard of predicted hits.
module bitmap_hit_enumerator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_WORDS   = bhe_pkg::MAP_WORDS_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 230;

    typedef struct packed {
        logic [bhe_pkg::INDEX_W-1:0] index;
        logic [bhe_pkg::HITS_W-1:0]  number;
        logic                        last;
    } hit_t;

    class hit_tracker;
        logic [16:0]                word_num;
        logic [bhe_pkg::HITS_W-1:0] hit_count;
        hit_t                       pending_hits[$];
        int                         errors;

        function new();
            word_num = '0;
            hit_count = '0;
            errors = 0;
        endfunction

        function void note_word(logic [bhe_pkg::WORD_BITS-1:0] w, logic s);
            int   lowest;
            hit_t h;
            logic [31:0] flat;
            if (s)
            begin
                word_num = '0;
                hit_count = '0;
            end
            if (word_num >= MAP_WORDS)
            begin
                word_num = 17'(MAP_WORDS);
                return;
            end
            lowest = 0;
            for (int pos = 0; pos < bhe_pkg::WORD_BITS; pos++)
            begin
                if (w[31 - pos])
                    lowest = pos;
            end
            for (int pos = 0; pos < bhe_pkg::WORD_BITS; pos++)
            begin
                if (w[31 - pos])
                begin
                    if (hit_count != {bhe_pkg::HITS_W{1'b1}})
                        hit_count++;
                    flat = 32'(word_num) * bhe_pkg::WORD_BITS + 32'(pos);
                    h.index = flat[bhe_pkg::INDEX_W-1:0];
                    h.number = hit_count;
                    h.last = (pos == lowest);
                    pending_hits.push_back(h);
                end
            end
            if (word_num < MAP_WORDS)
                word_num++;
        endfunction

        function void check_hit(logic [bhe_pkg::INDEX_W-1:0] idx,
                                logic [bhe_pkg::HITS_W-1:0] num, logic lst);
            hit_t h;
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected hit, expected none, got index %0d number %0d last %0d",
                         $time, idx, num, lst);
                errors++;
                return;
            end
            h = pending_hits.pop_front();
            if (idx !== h.index)
            begin
                $display("%0t: hit_index expected %0d, got %0d", $time, h.index, idx);
                errors++;
            end
            if (num !== h.number)
            begin
                $display("%0t: hit_number expected %0d, got %0d", $time, h.number, num);
                errors++;
            end
            if (lst !== h.last)
            begin
                $display("%0t: last_in_word expected %0d, got %0d", $time, h.last, lst);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_hits.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [bhe_pkg::WORD_BITS-1:0] map_word;
    logic                          map_start;
    logic                          out_valid;
    logic                          out_stall;
    logic [bhe_pkg::INDEX_W-1:0]   hit_index;
    logic [bhe_pkg::HITS_W-1:0]    hit_number;
    logic                          last_in_word;

    hit_tracker tracker = new();
    int  quiet_cycles = 0;
    int  hold_cycles = 0;
    bit  no_idle = 0;

    bitmap_hit_enumerator #(
        .MAP_WORDS(MAP_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .map_word(map_word),
        .map_start(map_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit_index(hit_index),
        .hit_number(hit_number),
        .last_in_word(last_in_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_word(map_word, map_start);
            if (out_valid && !out_stall)
                tracker.check_hit(hit_index, hit_number, last_in_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < 15);
        end
    end

    task automatic send_word(input logic [bhe_pkg::WORD_BITS-1:0] w, input logic s);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        map_word <= w;
        map_start <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_hits();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.outstanding() > 0)
            @(negedge clk);
    endtask

    function automatic logic [bhe_pkg::WORD_BITS-1:0] random_map_word();
        logic [bhe_pkg::WORD_BITS-1:0] w;
        int                            sel;
        w = '0;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            repeat ($urandom_range(3, 1))
                w[$urandom_range(31)] = 1'b1;
        end
        else if (sel < 60)
            w = $urandom;
        else if (sel < 75)
            w = '0;
        else if (sel < 85)
            w = '1;
        else
            w[$urandom_range(31)] = 1'b1;
        return w;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        map_word = '0;
        map_start = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(32'h8000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0001_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);

        hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_word(32'hFFFF_FFFF ^ (32'h1 << i), 1'b0);
        drain_hits();

        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hC000_0003, 1'b1);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            no_idle = (i >= 100 && i < 160);
            send_word(random_map_word(), ($urandom_range(99) < 10));
        end
        no_idle = 0;

        drain_hits();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
